### hw/rtl/swept_sphere_first_collision_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the swept-sphere first collision block
// Immediate-implication and next-cycle-implication checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SWEPT_SPHERE_FIRST_COLLISION_TOP_ASSERT_SVH
`define SWEPT_SPHERE_FIRST_COLLISION_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SSFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssfc assertion failed");
`define SSFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssfc assertion failed");
`else
`define SSFC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SSFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/ssfc_pkg.sv
// ----------------------------------------------------------------------------
// ssfc_pkg
// Shared constants and codes for the swept-sphere first collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int INDEX_BITS_DEF  = 16;

  // magnitudes are brought below 2^NORM_BITS before squaring
  localparam int NORM_BITS = 29;

  localparam logic [2:0] CLASS_BOUND = 3'd3;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_NEIGHBOR = 2'd1,
    OP_EXCLUDED = 2'd2
  } op_t;

endpackage

`default_nettype wire

### hw/rtl/swept_sphere_first_collision_top.sv
// ----------------------------------------------------------------------------
// swept_sphere_first_collision_top
// Earliest contact of a moving sphere against a list of neighbour spheres.
// ----------------------------------------------------------------------------
// Usage. Input words arrive on s_axis; s_axis_tuser carries the op (start,
// neighbour, excluded neighbour). A start word loads the mover; neighbour
// words are tested one at a time; the word with tlast set closes the list and
// one result word leaves on m_axis.
// Steps (CW = COORD_WIDTH):
//   start / excluded word: taken in the idle state.
//   neighbour word: load the three axes, a normalising shift s (0..CW-29),
//   the products a, c, B and the discriminant on one bit-serial shift-add
//   multiplier, a two-bit-per-cycle square root, the division for each
//   root candidate in range, then the best-time update.
//   closing step: end time, then the moved position per axis on the multiplier, then the
//   result word is registered.
// One word is worked on at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so the next list may start while it
// waits; a second result waits until the first is taken.
// Reset (rst, synchronous): mover at origin with zero radius, best time 1.0,
// no hit, held class 0, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "swept_sphere_first_collision_top_assert.svh"

module swept_sphere_first_collision_top #(
  parameter int COORD_WIDTH = ssfc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ssfc_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS  = ssfc_pkg::INDEX_BITS_DEF,
  localparam int CW    = COORD_WIDTH,
  localparam int IN_W  = 7 * CW - 1 + INDEX_BITS + 4,
  localparam int IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W = 1 + INDEX_BITS + 3 + FRAC_BITS + 1 + 3 * CW,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, radius, neighbor_index,
  // neighbor_type, neighbor_bound
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // op
  input  logic [1:0]        s_axis_tuser,
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // hit, hit_index, collision_class, hit_time, new_x, new_y, new_z
  output logic [OUT_TW-1:0] m_axis_tdata
);

  localparam int F    = FRAC_BITS;
  localparam int IB   = INDEX_BITS;
  localparam int MW   = CW + 1;
  localparam int NB   = ssfc_pkg::NORM_BITS;
  localparam int PW   = (MW < NB) ? MW : NB;
  localparam int OW   = 2 * PW + 2;
  localparam int AW   = 2 * OW + 2;
  localparam int XW   = 2 * OW;
  localparam int SI   = OW + 1;
  localparam int RW   = SI + 3;
  localparam int NW   = OW + 3;
  localparam int CNTW = $clog2(AW + 1);
  localparam int OFF_RAD = 6 * CW;
  localparam int OFF_IDX = 7 * CW - 1;
  localparam int OFF_TYP = OFF_IDX + IB;
  localparam int OFF_BND = OFF_TYP + 3;
  localparam int EPS     = ((1 << F) + 5000) / 10000;
  localparam logic [F:0] ONE_T   = (F + 1)'(1) << F;
  localparam logic [F:0] TWO_EPS = (F + 1)'(2 * EPS);
  localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);
  // product sequence: a, then c, then B, then the discriminant
  localparam logic [3:0] P_A_END  = 4'd2;
  localparam logic [3:0] P_RS     = 4'd6;
  localparam logic [3:0] P_C_END  = 4'd6;
  localparam logic [3:0] P_B_END  = 4'd9;
  localparam logic [3:0] P_BB     = 4'd10;
  localparam logic [3:0] P_AC     = 4'd11;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_NORM, ST_MUL_LD, ST_MUL_RUN, ST_MUL_END, ST_CHK,
    ST_SQRT, ST_ROOT_CHK, ST_DIV, ST_UPD, ST_NB_DONE, ST_FIN_T, ST_FIN_LD,
    ST_FIN_RUN, ST_FIN_END, ST_OUT
  } state_t;

  state_t state;

  logic signed [CW-1:0] mover_pos [3];
  logic signed [CW-1:0] mover_target [3];
  logic [CW-2:0]        mover_radius;
  logic signed [CW-1:0] npos [3];
  logic [IB-1:0]        nidx;
  logic [2:0]           ncls;
  logic                 nlast;

  logic [F:0]    best_time;
  logic [IB-1:0] best_index;
  logic [2:0]    best_class;
  logic          found;
  logic [2:0]    held_class;

  logic [MW-1:0] dm [3];
  logic [MW-1:0] em [3];
  logic [2:0]    dneg;
  logic [2:0]    eneg;
  logic [MW-1:0] rsm;
  logic [MW-1:0] or_mag;
  logic [1:0]    ax;

  logic [AW-1:0]   acc;
  logic [XW-1:0]   mul_x;
  logic [OW-1:0]   mul_y;
  logic            mul_sub;
  logic [CNTW-1:0] cnt;
  logic [3:0]      pidx;
  logic [OW-1:0]   a_reg;
  logic [OW:0]     c_reg;
  logic [OW:0]     bb_reg;
  logic [RW-1:0]   sq_rem;
  logic [SI-1:0]   sq_root;
  logic            cand;
  logic [OW:0]     dv_rem;
  logic [F-1:0]    dv_q;
  logic [F:0]      tfin;
  logic            fneg;

  logic          o_hit;
  logic [IB-1:0] o_idx;
  logic [2:0]    o_cls;
  logic [F:0]    o_time;
  logic [CW-1:0] o_new [3];

  // ---- combinational helpers ----
  logic [MW-1:0] ld_d, ld_e, ld_dm, ld_em;
  logic [OW-1:0] op_a, op_b, bb_mag, c_mag;
  logic          op_sub;
  logic [CNTW-1:0] op_len;
  logic [RW-1:0] sq_sh, sq_trial;
  logic [NW-1:0] n_val;
  logic          n_ok;
  logic [OW:0]   dv_sh;
  logic [MW-1:0] f_off, f_new;
  logic          out_load;
  logic          nb_accept;

  always_comb begin
    ld_d  = {mover_target[ax][CW-1], mover_target[ax]} - {mover_pos[ax][CW-1], mover_pos[ax]};
    ld_e  = {npos[ax][CW-1], npos[ax]} - {mover_pos[ax][CW-1], mover_pos[ax]};
    ld_dm = ld_d[MW-1] ? (~ld_d + MW'(1)) : ld_d;
    ld_em = ld_e[MW-1] ? (~ld_e + MW'(1)) : ld_e;
  end

  assign bb_mag = bb_reg[OW] ? OW'(~bb_reg + (OW + 1)'(1)) : bb_reg[OW-1:0];
  assign c_mag  = c_reg[OW] ? OW'(~c_reg + (OW + 1)'(1)) : c_reg[OW-1:0];

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    op_len = CNTW'(PW);
    unique case (pidx)
      4'd0: begin op_a = OW'(dm[0][PW-1:0]); op_b = op_a; end
      4'd1: begin op_a = OW'(dm[1][PW-1:0]); op_b = op_a; end
      4'd2: begin op_a = OW'(dm[2][PW-1:0]); op_b = op_a; end
      4'd3: begin op_a = OW'(em[0][PW-1:0]); op_b = op_a; end
      4'd4: begin op_a = OW'(em[1][PW-1:0]); op_b = op_a; end
      4'd5: begin op_a = OW'(em[2][PW-1:0]); op_b = op_a; end
      P_RS: begin
        op_a   = OW'(rsm[PW-1:0]);
        op_b   = op_a;
        op_sub = 1'b1;
      end
      4'd7: begin
        op_a = OW'(em[0][PW-1:0]); op_b = OW'(dm[0][PW-1:0]); op_sub = eneg[0] ^ dneg[0];
      end
      4'd8: begin
        op_a = OW'(em[1][PW-1:0]); op_b = OW'(dm[1][PW-1:0]); op_sub = eneg[1] ^ dneg[1];
      end
      4'd9: begin
        op_a = OW'(em[2][PW-1:0]); op_b = OW'(dm[2][PW-1:0]); op_sub = eneg[2] ^ dneg[2];
      end
      P_BB: begin
        op_a   = bb_mag;
        op_b   = bb_mag;
        op_len = CNTW'(OW);
      end
      P_AC: begin
        op_a   = a_reg;
        op_b   = c_mag;
        op_sub = !c_reg[OW];
        op_len = CNTW'(OW);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // root step: bring down two bits of the discriminant
  assign sq_sh    = {sq_rem[RW-3:0], acc[AW-1:AW-2]};
  assign sq_trial = RW'({sq_root, 2'b01});

  // candidate numerator B -/+ Q and its range check 0 <= n < a
  always_comb begin
    if (cand) begin
      n_val = {{2{bb_reg[OW]}}, bb_reg} + NW'(sq_root);
    end else begin
      n_val = {{2{bb_reg[OW]}}, bb_reg} - NW'(sq_root);
    end
    n_ok = !n_val[NW-1] && (n_val < NW'(a_reg));
  end

  assign dv_sh = {dv_rem[OW-1:0], 1'b0};

  assign f_off = acc[F +: MW];
  assign f_new = fneg ? ({mover_pos[ax][CW-1], mover_pos[ax]} - f_off)
                      : ({mover_pos[ax][CW-1], mover_pos[ax]} + f_off);

  assign s_axis_tready = (state == ST_IDLE);

  // result register free (or being emptied) while a result is ready
  assign out_load  = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign nb_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ssfc_pkg::OP_NEIGHBOR);

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OUT_W-1:0] = {o_new[2], o_new[1], o_new[0], o_time, o_cls, o_idx, o_hit};
  end

  // ---- sequencer and datapath ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      best_time     <= ONE_T;
      best_index    <= '0;
      best_class    <= '0;
      found         <= 1'b0;
      held_class    <= '0;
      mover_radius  <= '0;
      for (int i = 0; i < 3; i++) begin
        mover_pos[i]    <= '0;
        mover_target[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            nlast <= s_axis_tlast;
            unique case (s_axis_tuser)
              ssfc_pkg::OP_START: begin
                for (int i = 0; i < 3; i++) begin
                  mover_pos[i]    <= s_axis_tdata[i*CW +: CW];
                  mover_target[i] <= s_axis_tdata[(i+3)*CW +: CW];
                end
                mover_radius <= s_axis_tdata[OFF_RAD +: CW-1];
                best_time    <= ONE_T;
                best_index   <= '0;
                best_class   <= '0;
                found        <= 1'b0;
                state        <= s_axis_tlast ? ST_FIN_T : ST_IDLE;
              end
              ssfc_pkg::OP_NEIGHBOR: begin
                for (int i = 0; i < 3; i++) begin
                  npos[i] <= s_axis_tdata[i*CW +: CW];
                end
                nidx  <= s_axis_tdata[OFF_IDX +: IB];
                ncls  <= s_axis_tdata[OFF_BND] ? ssfc_pkg::CLASS_BOUND
                                               : s_axis_tdata[OFF_TYP +: 3];
                rsm   <= MW'(s_axis_tdata[OFF_RAD +: CW-1]) + MW'(mover_radius);
                ax    <= '0;
                state <= ST_LOAD;
              end
              default: begin
                state <= s_axis_tlast ? ST_FIN_T : ST_IDLE;
              end
            endcase
          end
        end
        ST_LOAD: begin
          dm[ax]   <= ld_dm;
          em[ax]   <= ld_em;
          dneg[ax] <= ld_d[MW-1];
          eneg[ax] <= ld_e[MW-1];
          if (ax == 2'd0) begin
            or_mag <= rsm | ld_dm | ld_em;
          end else begin
            or_mag <= or_mag | ld_dm | ld_em;
          end
          if (ax == 2'd2) begin
            state <= ST_NORM;
          end
          ax <= ax + 2'd1;
        end
        ST_NORM: begin
          // one bit of right shift per cycle until all magnitudes fit
          if ((or_mag >> NB) != '0) begin
            or_mag <= or_mag >> 1;
            rsm    <= rsm >> 1;
            for (int i = 0; i < 3; i++) begin
              dm[i] <= dm[i] >> 1;
              em[i] <= em[i] >> 1;
            end
          end else begin
            pidx  <= '0;
            acc   <= '0;
            state <= ST_MUL_LD;
          end
        end
        ST_MUL_LD: begin
          mul_x   <= XW'(op_a);
          mul_y   <= op_b;
          mul_sub <= op_sub;
          cnt     <= op_len;
          state   <= ST_MUL_RUN;
        end
        ST_MUL_RUN: begin
          if (mul_y[0]) begin
            acc <= mul_sub ? (acc - AW'(mul_x)) : (acc + AW'(mul_x));
          end
          mul_x <= mul_x << 1;
          mul_y <= mul_y >> 1;
          cnt   <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= ST_MUL_END;
          end
        end
        ST_MUL_END: begin
          pidx  <= pidx + 4'd1;
          state <= (pidx == P_AC) ? ST_CHK : ST_MUL_LD;
          priority case (pidx)
            P_A_END: begin
              a_reg <= acc[OW-1:0];
              acc   <= '0;
            end
            P_C_END: begin
              c_reg <= acc[OW:0];
              acc   <= '0;
            end
            P_B_END: begin
              bb_reg <= acc[OW:0];
              acc    <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_CHK: begin
          // no motion or negative discriminant: no contact
          if (a_reg == '0 || acc[AW-1]) begin
            state <= ST_NB_DONE;
          end else begin
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= CNTW'(SI);
            state   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_sh >= sq_trial) begin
            sq_rem  <= sq_sh - sq_trial;
            sq_root <= {sq_root[SI-2:0], 1'b1};
          end else begin
            sq_rem  <= sq_sh;
            sq_root <= {sq_root[SI-2:0], 1'b0};
          end
          acc <= acc << 2;
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            cand  <= 1'b0;
            state <= ST_ROOT_CHK;
          end
        end
        ST_ROOT_CHK: begin
          if (n_ok) begin
            dv_rem <= (OW + 1)'(n_val[OW-1:0]);
            dv_q   <= '0;
            cnt    <= CNTW'(F);
            state  <= ST_DIV;
          end else if (!cand) begin
            cand <= 1'b1;
          end else begin
            state <= ST_NB_DONE;
          end
        end
        ST_DIV: begin
          if (dv_sh >= {1'b0, a_reg}) begin
            dv_rem <= dv_sh - {1'b0, a_reg};
            dv_q   <= {dv_q[F-2:0], 1'b1};
          end else begin
            dv_rem <= dv_sh;
            dv_q   <= {dv_q[F-2:0], 1'b0};
          end
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          // strict compare: on a tie the earlier neighbour stays
          if ((F + 1)'(dv_q) < best_time) begin
            best_time  <= (F + 1)'(dv_q);
            best_index <= nidx;
            best_class <= ncls;
            found      <= 1'b1;
          end
          if (!cand) begin
            cand  <= 1'b1;
            state <= ST_ROOT_CHK;
          end else begin
            state <= ST_NB_DONE;
          end
        end
        ST_NB_DONE: begin
          state <= nlast ? ST_FIN_T : ST_IDLE;
        end
        ST_FIN_T: begin
          tfin  <= (best_time >= TWO_EPS) ? (best_time - TWO_EPS) : '0;
          ax    <= '0;
          state <= ST_FIN_LD;
        end
        ST_FIN_LD: begin
          acc     <= HALF;
          mul_x   <= XW'(ld_dm);
          mul_y   <= OW'(tfin);
          mul_sub <= 1'b0;
          fneg    <= ld_d[MW-1];
          cnt     <= CNTW'(F + 1);
          state   <= ST_FIN_RUN;
        end
        ST_FIN_RUN: begin
          if (mul_y[0]) begin
            acc <= acc + AW'(mul_x);
          end
          mul_x <= mul_x << 1;
          mul_y <= mul_y >> 1;
          cnt   <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= ST_FIN_END;
          end
        end
        ST_FIN_END: begin
          mover_pos[ax] <= f_new[CW-1:0];
          ax            <= ax + 2'd1;
          state         <= (ax == 2'd2) ? ST_OUT : ST_FIN_LD;
        end
        ST_OUT: begin
          if (out_load) begin
            o_hit         <= found;
            o_idx         <= found ? best_index : '0;
            o_cls         <= found ? best_class : held_class;
            held_class    <= found ? best_class : held_class;
            o_time        <= tfin;
            for (int i = 0; i < 3; i++) begin
              o_new[i] <= mover_pos[i];
            end
            best_time <= ONE_T;
            found     <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- checks ----
  `SSFC_ASSERT_NOW(a_idle_time, clk, rst, !found, best_time == ONE_T)
  `SSFC_ASSERT_NOW(a_time_range, clk, rst, m_axis_tvalid, o_time <= (ONE_T - TWO_EPS))
  `SSFC_ASSERT_NOW(a_nohit_index, clk, rst, m_axis_tvalid && !o_hit, o_idx == '0)
  `SSFC_ASSERT_NEXT(a_nb_busy, clk, rst, nb_accept, !s_axis_tready)

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the swept-sphere first collision block. Words are
// driven in bursts, results are taken under a varying stall pattern, and each
// result is checked against a bit-exact model of the collision search.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam logic [1:0]  OP_SPARE  = 2'd3;  // unused selector, skipped
  localparam longint      TIME_ONE  = 64'd65536;
  localparam longint      EPS_TIME  = (TIME_ONE + 5000) / 10000;
  localparam longint      NORM_LIM  = 64'd1 << ssfc_pkg::NORM_BITS;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam int          N_ITEMS   = 1250;
  localparam int          IDLE_LIM  = 10000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] px, py, pz, tx, ty, tz;
    logic [30:0] rad;
    logic [15:0] idx;
    logic [2:0]  typ;
    logic        bnd;
    logic        last;
  } nb_word_t;

  typedef struct {
    logic        hit;
    logic [15:0] idx;
    logic [2:0]  cls;
    logic [16:0] t;
    logic [31:0] nx, ny, nz;
  } contact_t;

  // Collision search model plus the queue of contacts still to come out.
  class collision_board;
    longint          mpos[3], mtgt[3];
    longint unsigned mrad, btime, bidx, bcls;
    bit              found;
    logic [2:0]      held;
    contact_t        contact_q[$];
    int              errors;

    function new();
      foreach (mpos[i]) begin
        mpos[i] = 0;
        mtgt[i] = 0;
      end
      mrad = 0; btime = TIME_ONE; bidx = 0; bcls = 0; found = 0; held = 0;
      errors = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned root_floor(logic [127:0] v);
      longint unsigned r, c;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
    endfunction

    function void try_time(longint n, longint unsigned a, longint unsigned id,
                           longint unsigned cl);
      longint unsigned rem, q;
      if (n < 0 || unsigned'(n) >= a) return;
      rem = n; q = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= a) begin
          rem -= a;
          q |= 1;
        end
      end
      if (q < btime) begin
        btime = q; bidx = id; bcls = cl; found = 1;
      end
    endfunction

    function void sweep_neighbour(nb_word_t w);
      longint          d[3], e[3], np[3], bb, cc, sq;
      longint unsigned rs, maxm, a, ee;
      logic [127:0]    disc, ac;
      int              s;
      np[0] = longint'($signed(w.px));
      np[1] = longint'($signed(w.py));
      np[2] = longint'($signed(w.pz));
      rs = longint'(w.rad) + mrad;
      maxm = rs;
      for (int i = 0; i < 3; i++) begin
        d[i] = mtgt[i] - mpos[i];
        e[i] = np[i] - mpos[i];
        if (mag(d[i]) > maxm) maxm = mag(d[i]);
        if (mag(e[i]) > maxm) maxm = mag(e[i]);
      end
      s = 0;
      while ((maxm >> s) >= NORM_LIM) s++;
      rs = rs >> s;
      a = 0; ee = 0; bb = 0;
      for (int i = 0; i < 3; i++) begin
        // shift magnitude, keep sign
        d[i] = d[i] < 0 ? -longint'(mag(d[i]) >> s) : longint'(mag(d[i]) >> s);
        e[i] = e[i] < 0 ? -longint'(mag(e[i]) >> s) : longint'(mag(e[i]) >> s);
        a += d[i] * d[i];
        ee += e[i] * e[i];
        bb += e[i] * d[i];
      end
      if (a == 0) return;  // no motion
      cc = longint'(ee) - longint'(rs * rs);
      disc = {64'd0, mag(bb)} * {64'd0, mag(bb)};
      ac = {64'd0, a} * {64'd0, mag(cc)};
      if (cc < 0) disc = disc + ac;
      else if (disc < ac) return;  // misses
      else disc = disc - ac;
      sq = root_floor(disc);
      try_time(bb - sq, a, w.idx, w.bnd ? ssfc_pkg::CLASS_BOUND : w.typ);
      try_time(bb + sq, a, w.idx, w.bnd ? ssfc_pkg::CLASS_BOUND : w.typ);
    endfunction

    function void note_word(nb_word_t w);
      contact_t        c;
      longint          t, d, nv;
      longint unsigned m, off;
      if (w.op == ssfc_pkg::OP_START) begin
        mpos[0] = longint'($signed(w.px));
        mpos[1] = longint'($signed(w.py));
        mpos[2] = longint'($signed(w.pz));
        mtgt[0] = longint'($signed(w.tx));
        mtgt[1] = longint'($signed(w.ty));
        mtgt[2] = longint'($signed(w.tz));
        mrad = 64'(w.rad); btime = TIME_ONE; bidx = 0; bcls = 0; found = 0;
      end else if (w.op == ssfc_pkg::OP_NEIGHBOR) begin
        sweep_neighbour(w);
      end
      if (!w.last) return;
      if (found) held = 3'(bcls);
      t = btime < 2 * EPS_TIME ? 0 : btime - 2 * EPS_TIME;
      c.hit = found;
      c.idx = 16'(found ? bidx : 64'd0);
      c.cls = held;
      c.t = 17'(t);
      for (int i = 0; i < 3; i++) begin
        d = mtgt[i] - mpos[i];
        m = mag(d);
        off = t * (m >> 16) + ((t * (m & 64'hFFFF) + 64'd32768) >> 16);
        nv = mpos[i] + (d < 0 ? -longint'(off) : longint'(off));
        mpos[i] = nv;
        if (i == 0) c.nx = nv[31:0];
        else if (i == 1) c.ny = nv[31:0];
        else c.nz = nv[31:0];
      end
      btime = TIME_ONE;
      found = 0;
      contact_q.push_back(c);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [135:0] r);
      contact_t c;
      if (contact_q.size() == 0) begin
        report($sformatf("result word %h with none expected", r));
        return;
      end
      c = contact_q.pop_front();
      if (r[0] !== c.hit) report($sformatf("hit %b, want %b", r[0], c.hit));
      if (r[16:1] !== c.idx) report($sformatf("index %h, want %h", r[16:1], c.idx));
      if (r[19:17] !== c.cls) report($sformatf("class %0d, want %0d", r[19:17], c.cls));
      if (r[36:20] !== c.t) report($sformatf("time %h, want %h", r[36:20], c.t));
      if (r[68:37] !== c.nx) report($sformatf("new_x %h, want %h", r[68:37], c.nx));
      if (r[100:69] !== c.ny) report($sformatf("new_y %h, want %h", r[100:69], c.ny));
      if (r[132:101] !== c.nz) report($sformatf("new_z %h, want %h", r[132:101], c.nz));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, radius, neighbor_index,
  // neighbor_type, neighbor_bound
  logic [247:0] s_axis_tdata = '0;
  // op
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // hit, hit_index, collision_class, hit_time, new_x, new_y, new_z
  logic [135:0] m_axis_tdata;

  collision_board board = new();
  int      words_sent = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  longint  gen_pos[3], gen_dir[3];  // rough mover track for aiming neighbours

  always #1 clk = ~clk;

  swept_sphere_first_collision_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic nb_word_t mk(logic [1:0] op, logic [31:0] px, py, pz, tx, ty, tz,
                                  logic [30:0] rad, logic [15:0] idx, logic [2:0] typ,
                                  logic bnd, logic last);
    nb_word_t w;
    w.op = op; w.px = px; w.py = py; w.pz = pz; w.tx = tx; w.ty = ty; w.tz = tz;
    w.rad = rad; w.idx = idx; w.typ = typ; w.bnd = bnd; w.last = last;
    return w;
  endfunction

  function automatic nb_word_t rand_word();
    return mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 31'($urandom), 16'($urandom), 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic longint near(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Sender: random bursts with random gaps; valid stays high across a burst.
  task automatic send_word(nb_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, w.bnd, w.typ, w.idx, w.rad, w.tz, w.ty, w.tx,
                      w.pz, w.py, w.px};
    s_axis_tuser  <= w.op;
    s_axis_tlast  <= w.last;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // One list: optional start word, then neighbours (aimed near the path unless wide).
  task automatic send_list(bit no_start, bit wide);
    nb_word_t w;
    int       n, k, r;
    n = $urandom_range(no_start ? 1 : 0, 4);
    if (!no_start) begin
      w = rand_word();
      if (!wide) begin
        w.px = 32'(near(1 << 20)); w.py = 32'(near(1 << 20)); w.pz = 32'(near(1 << 20));
        w.tx = 32'(longint'($signed(w.px)) + near(1 << 19));
        w.ty = 32'(longint'($signed(w.py)) + near(1 << 19));
        w.tz = 32'(longint'($signed(w.pz)) + near(1 << 19));
        w.rad = 31'($urandom_range(0, 1 << 16));
      end
      w.op = ssfc_pkg::OP_START;
      w.last = (n == 0);
      gen_pos[0] = longint'($signed(w.px));
      gen_pos[1] = longint'($signed(w.py));
      gen_pos[2] = longint'($signed(w.pz));
      gen_dir[0] = longint'($signed(w.tx)) - gen_pos[0];
      gen_dir[1] = longint'($signed(w.ty)) - gen_pos[1];
      gen_dir[2] = longint'($signed(w.tz)) - gen_pos[2];
      send_word(w);
    end
    for (int i = 0; i < n; i++) begin
      w = rand_word();
      if (!wide) begin
        k = $urandom_range(0, 300);
        w.px = 32'(gen_pos[0] + ((gen_dir[0] * k) >>> 8) + near(1 << 17));
        w.py = 32'(gen_pos[1] + ((gen_dir[1] * k) >>> 8) + near(1 << 17));
        w.pz = 32'(gen_pos[2] + ((gen_dir[2] * k) >>> 8) + near(1 << 17));
        w.rad = 31'($urandom_range(0, 1 << 17));
      end
      r = $urandom_range(0, 9);
      w.op = r < 7 ? ssfc_pkg::OP_NEIGHBOR : (r < 9 ? ssfc_pkg::OP_EXCLUDED : OP_SPARE);
      w.last = (i == n - 1);
      send_word(w);
    end
  endtask

  // Accepted words go to the model, accepted results are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_word(mk(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                           s_axis_tdata[95:64], s_axis_tdata[127:96],
                           s_axis_tdata[159:128], s_axis_tdata[191:160],
                           s_axis_tdata[222:192], s_axis_tdata[238:223],
                           s_axis_tdata[241:239], s_axis_tdata[242], s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  // Watchdog: too long with nothing moving on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: stall pattern switching between modes, plus one long hold-off
  // mid-run so the result register fills and the input backs up.
  initial begin
    int  mode, mode_left, hold;
    bit  hold_done;
    mode = 0; mode_left = 0; hold = 0; hold_done = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_sent >= 400) begin
        hold_done = 1;
        hold = 3000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 9) != 0);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // neighbour before any start: mover has no motion
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'h1_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h1_0000, 16'd5, 3'd1, 1'b0, 1'b1));
    // head-on list: tie between two identical neighbours, skipped ones, a miss
    send_word(mk(ssfc_pkg::OP_START, 32'd0, 32'd0, 32'd0, 32'hA_0000, 32'd0, 32'd0,
                 31'h1_0000, 16'd0, 3'd0, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'h5_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h1_0000, 16'd1, 3'd2, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'h5_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h1_0000, 16'd2, 3'd2, 1'b1, 1'b0));
    send_word(mk(ssfc_pkg::OP_EXCLUDED, 32'h1_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h1_0000, 16'd3, 3'd0, 1'b0, 1'b0));
    send_word(mk(OP_SPARE, 32'h2_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h1_0000, 16'd4, 3'd0, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'd0, 32'h64_0000, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h1_0000, 16'd6, 3'd1, 1'b0, 1'b1));
    // list with no start: carries on from the moved position, odd type
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'h9_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'h2_0000, 16'd7, 3'd7, 1'b0, 1'b1));
    // zero motion
    send_word(mk(ssfc_pkg::OP_START, 32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h3_0000,
                 32'h3_0000, 32'h3_0000, 31'h1_0000, 16'd0, 3'd0, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'h3_0000, 32'h3_0000, 32'h3_0000, 32'd0, 32'd0,
                 32'd0, 31'h1_0000, 16'd8, 3'd4, 1'b0, 1'b1));
    // extreme coordinates and radii, normalising shift at its largest
    send_word(mk(ssfc_pkg::OP_START, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                 COORD_MAX, 31'h7FFF_FFFF, 16'hFFFF, 3'd7, 1'b1, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, 32'd0, 32'd0, 32'd0, COORD_MIN, COORD_MIN,
                 COORD_MIN, 31'h7FFF_FFFF, 16'hFFFF, 3'd4, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MAX, 31'd0, 16'h0, 3'd0, 1'b1, 1'b1));
    // neighbour overlapping the start point
    send_word(mk(ssfc_pkg::OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                 COORD_MIN, 31'd0, 16'd0, 3'd0, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_NEIGHBOR, COORD_MAX, COORD_MAX, COORD_MAX, 32'd0, 32'd0,
                 32'd0, 31'h1_0000, 16'h1234, 3'd3, 1'b0, 1'b0));
    send_word(mk(ssfc_pkg::OP_EXCLUDED, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                 31'd0, 16'd0, 3'd0, 1'b0, 1'b1));
    // start word that closes its own list
    send_word(mk(ssfc_pkg::OP_START, 32'h1_0000, 32'd0, 32'd0, 32'h2_0000, 32'd0, 32'd0,
                 31'd1, 16'd0, 3'd0, 1'b0, 1'b1));

    while (words_sent < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0: send_word(rand_word());
        1: send_list(1'b1, 1'b0);
        2: send_list(1'b0, 1'b1);
        default: send_list(1'b0, 1'b0);
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (board.contact_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (board.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/ssfc_pkg.sv
hw/rtl/swept_sphere_first_collision_top.sv
sim/tb_top.sv
